/* hw/rtl/psm_pkg.sv */
// psm_pkg: shared constants, types and helpers of the pixel stack median block
// depends on nothing; used by every module under hw/rtl
package psm_pkg;

   localparam int MAX_IMAGES = 16;
   localparam int SAMPLE_W   = 8;
   localparam int CFG_W      = 5;
   localparam int CNT_W      = $clog2(MAX_IMAGES + 1);
   localparam int CMP_W      = (CFG_W > CNT_W) ? CFG_W : CNT_W;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [CNT_W-1:0]    count_type;
   typedef logic [CFG_W-1:0]    cfg_type;

   typedef struct packed {
      logic accept;
      logic occupied;
      logic slot;
      logic snap_load;
   } cell_ctl_type;

   // image count clamped to 1..MAX_IMAGES
   function automatic count_type effective_count(input cfg_type cfg);
      logic [CMP_W-1:0] c;
      count_type        r;
      c = CMP_W'(cfg);
      if (c == '0) begin
         r = count_type'(1);
      end else if (c > CMP_W'(MAX_IMAGES)) begin
         r = count_type'(MAX_IMAGES);
      end else begin
         r = count_type'(c);
      end
      return r;
   endfunction

endpackage

/* hw/rtl/pixel_stack_median.sv */
// pixel_stack_median: per-pixel median over a stack of gray images
// last sample loads the snapshot row; the median stage takes it and raises rsp_valid
// throughput: one sample per cycle unless stalled; every chain cell compares at once
// a finished chain is copied to a snapshot row so the next position starts at once
// reset (synchronous): store empty, image count 1, no result pending; no clearing pass
// depends on psm_pkg, psm_cell, psm_median
module pixel_stack_median (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  psm_pkg::sample_type req_pixel_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output psm_pkg::sample_type rsp_median_value,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  psm_pkg::cfg_type    csr_num_images
);

   psm_pkg::cfg_type   cfg_ff, cfg_in;
   psm_pkg::count_type held_ff, held_in;
   psm_pkg::count_type snap_cnt_ff, snap_cnt_in;
   logic               snap_valid_ff, snap_valid_in;
   psm_pkg::count_type held_next;
   logic               accept, done, move, out_ready;

   psm_pkg::cell_ctl_type ctl   [psm_pkg::MAX_IMAGES];
   logic                  gts   [psm_pkg::MAX_IMAGES];
   psm_pkg::sample_type   vals  [psm_pkg::MAX_IMAGES];
   psm_pkg::sample_type   snaps [psm_pkg::MAX_IMAGES];

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign held_next = held_ff + psm_pkg::count_type'(1);
   assign done      = held_next >= psm_pkg::effective_count(cfg_ff);
   assign move      = snap_valid_ff && out_ready;
   assign req_stall = snap_valid_ff && !out_ready;

   for (genvar i = 0; i < psm_pkg::MAX_IMAGES; i++) begin : g_cell
      logic                left_gt;
      psm_pkg::sample_type left_val;
      if (i == 0) begin : g_first
         assign left_gt  = 1'b0;
         assign left_val = '0;
      end else begin : g_rest
         assign left_gt  = gts[i-1];
         assign left_val = vals[i-1];
      end
      assign ctl[i].accept    = accept;
      assign ctl[i].occupied  = psm_pkg::count_type'(i) < held_ff;
      assign ctl[i].slot      = psm_pkg::count_type'(i) == held_ff;
      assign ctl[i].snap_load = accept && done;
      psm_cell u_cell (
         .clock    (clock),
         .ctl      (ctl[i]),
         .sample   (req_pixel_sample),
         .left_gt  (left_gt),
         .left_val (left_val),
         .gt       (gts[i]),
         .val      (vals[i]),
         .snap     (snaps[i])
      );
   end

   psm_median u_median (
      .clock            (clock),
      .reset            (reset),
      .snap             (snaps),
      .count            (snap_cnt_ff),
      .take             (move),
      .ready            (out_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median_value (rsp_median_value)
   );

   always_comb begin
      cfg_in        = (csr_valid && csr_ready) ? csr_num_images : cfg_ff;
      held_in       = held_ff;
      snap_cnt_in   = snap_cnt_ff;
      snap_valid_in = snap_valid_ff;
      if (move) begin
         snap_valid_in = 1'b0;
      end
      if (accept) begin
         if (done) begin
            held_in       = '0;
            snap_cnt_in   = held_next;
            snap_valid_in = 1'b1;
         end else begin
            held_in = held_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= psm_pkg::cfg_type'(1);
         held_ff       <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         held_ff       <= held_in;
         snap_valid_ff <= snap_valid_in;
      end
      snap_cnt_ff <= snap_cnt_in;
   end

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff < psm_pkg::count_type'(psm_pkg::MAX_IMAGES))
      else $error("store count out of range");

   a_held_step: assert property (@(posedge clock) disable iff (reset)
      accept && !done |=> held_ff == $past(held_ff) + psm_pkg::count_type'(1))
      else $error("store count did not advance");

   a_snap_load: assert property (@(posedge clock) disable iff (reset)
      accept && done |=> snap_valid_ff && snap_cnt_ff != '0)
      else $error("snapshot not loaded on position end");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> snap_valid_ff && rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

endmodule

/* hw/rtl/psm_cell.sv */
// psm_cell: one cell of the insertion chain, holds one sorted sample and its snapshot
// depends on psm_pkg
module psm_cell (
   input  logic                 clock,
   input  psm_pkg::cell_ctl_type ctl,
   input  psm_pkg::sample_type  sample,
   input  logic                 left_gt,
   input  psm_pkg::sample_type  left_val,
   output logic                 gt,
   output psm_pkg::sample_type  val,
   output psm_pkg::sample_type  snap
);

   psm_pkg::sample_type val_ff, val_in;
   psm_pkg::sample_type snap_ff, snap_in;

   assign gt = ctl.occupied && (val_ff > sample);

   always_comb begin
      val_in = val_ff;
      if (ctl.accept && (gt || ctl.slot)) begin
         val_in = left_gt ? left_val : sample;
      end
      snap_in = ctl.snap_load ? val_in : snap_ff;
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      snap_ff <= snap_in;
   end

   assign val  = val_ff;
   assign snap = snap_ff;

endmodule

/* hw/rtl/psm_median.sv */
// psm_median: picks the two middle snapshot entries, averages them, holds the result
// depends on psm_pkg
module psm_median (
   input  logic                clock,
   input  logic                reset,
   input  psm_pkg::sample_type snap [psm_pkg::MAX_IMAGES],
   input  psm_pkg::count_type  count,
   input  logic                take,
   output logic                ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output psm_pkg::sample_type rsp_median_value
);

   logic                valid_ff, valid_in;
   psm_pkg::sample_type median_ff, median_in;
   psm_pkg::count_type  lo_idx, hi_idx;
   psm_pkg::sample_type lo_val, hi_val;
   logic [psm_pkg::SAMPLE_W:0] sum;

   always_comb begin
      lo_idx = (count - psm_pkg::count_type'(1)) >> 1;
      hi_idx = count >> 1;
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < psm_pkg::MAX_IMAGES; i++) begin
         if (lo_idx == psm_pkg::count_type'(i)) begin
            lo_val = lo_val | snap[i];
         end
         if (hi_idx == psm_pkg::count_type'(i)) begin
            hi_val = hi_val | snap[i];
         end
      end
      sum = {1'b0, lo_val} + {1'b0, hi_val};
   end

   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in  = valid_ff;
      median_in = median_ff;
      if (take) begin
         valid_in  = 1'b1;
         median_in = sum[psm_pkg::SAMPLE_W:1];
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      median_ff <= median_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_median_value = median_ff;

endmodule

/* sim/pixel_stack_median_checker.sv */
`timescale 1ns / 1ps
// pixel_stack_median_checker: watches the sample, median and image-count channels,
// predicts every median from its own sorted store and compares it with the block
// depends on psm_pkg for the port types
module pixel_stack_median_checker
   import psm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  sample_type req_pixel_sample,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  sample_type rsp_median_value,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  cfg_type    csr_num_images,
   output int         failures,
   output int         medians_pending,
   output int         medians_checked
);

   sample_type sorted_stack [MAX_IMAGES];
   int         stack_fill;
   cfg_type    image_count;
   sample_type median_queue [$];

   initial begin
      failures        = 0;
      medians_pending = 0;
      medians_checked = 0;
      stack_fill      = 0;
      image_count     = cfg_type'(1);
   end

   always @(posedge clock) begin : predict
      int         slot;
      int         stack_limit;
      logic [8:0] pair_sum;
      sample_type want;
      if (reset) begin
         stack_fill  = 0;
         image_count = cfg_type'(1);
         median_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            image_count = csr_num_images;
         end
         if (req_valid && !req_stall) begin
            slot = stack_fill;
            while (slot > 0 && sorted_stack[slot-1] > req_pixel_sample) begin
               sorted_stack[slot] = sorted_stack[slot-1];
               slot--;
            end
            sorted_stack[slot] = req_pixel_sample;
            stack_fill++;
            if (image_count == 0) begin
               stack_limit = 1;
            end else if (int'(image_count) > MAX_IMAGES) begin
               stack_limit = MAX_IMAGES;
            end else begin
               stack_limit = int'(image_count);
            end
            if (stack_fill >= stack_limit) begin
               if (stack_fill % 2 == 0) begin
                  pair_sum = {1'b0, sorted_stack[stack_fill/2]} +
                             {1'b0, sorted_stack[stack_fill/2 - 1]};
                  median_queue.push_back(pair_sum[8:1]);
               end else begin
                  median_queue.push_back(sorted_stack[(stack_fill-1)/2]);
               end
               stack_fill = 0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (median_queue.size() == 0) begin
               $error("median_value: no median expected, actual %0d", rsp_median_value);
               failures++;
            end else begin
               want = median_queue.pop_front();
               if (rsp_median_value !== want) begin
                  $error("median_value: expected %0d, actual %0d", want, rsp_median_value);
                  failures++;
               end
               medians_checked++;
            end
         end
      end
      medians_pending = median_queue.size();
   end

endmodule

/* sim/pixel_stack_median_test.sv */
`timescale 1ns / 1ps
// pixel_stack_median_test: drives samples and image-count writes into pixel_stack_median
// with random gaps and stalls; pixel_stack_median_checker predicts and compares
// depends on psm_pkg, pixel_stack_median, pixel_stack_median_checker
module pixel_stack_median_test;
   import psm_pkg::*;

   localparam int SAMPLE_TARGET = 1700;
   localparam int IDLE_LIMIT    = 2000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   sample_type req_pixel_sample = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   sample_type rsp_median_value;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   cfg_type    csr_num_images = '0;

   int failures;
   int medians_pending;
   int medians_checked;
   int samples_sent = 0;
   int count_writes = 0;
   int gap_mode = 1;

   always #4 clock = ~clock;

   pixel_stack_median uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_sample (req_pixel_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median_value (rsp_median_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_num_images   (csr_num_images)
   );

   pixel_stack_median_checker median_watch (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_sample (req_pixel_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median_value (rsp_median_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_num_images   (csr_num_images),
      .failures         (failures),
      .medians_pending  (medians_pending),
      .medians_checked  (medians_checked)
   );

   function automatic int pick_gap();
      int roll;
      if (gap_mode == 0) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic send_sample(input sample_type value);
      int   gap;
      logic taken;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pixel_sample <= value;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      samples_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (medians_pending != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_image_count(input cfg_type value);
      logic taken;
      wait_drained();
      csr_valid      <= 1'b1;
      csr_num_images <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      count_writes++;
   endtask

   // receiver: runs of no stall, light stall, and heavy stall with long holds
   initial begin : stall_driver
      int   stall_mode;
      int   mode_left;
      int   hold_left;
      logic stall_now;
      stall_mode = 0;
      mode_left  = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         stall_now = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
            stall_now = 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_left  = $urandom_range(20, 300);
            end
            mode_left--;
            if (stall_mode == 1) begin
               stall_now = ($urandom_range(0, 3) == 0);
            end else if (stall_mode == 2) begin
               stall_now = ($urandom_range(0, 1) == 0);
               if ($urandom_range(0, 39) == 0) begin
                  hold_left = $urandom_range(8, 40);
               end
            end
         end
         rsp_stall <= stall_now;
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int         phase;
      int         phase_len;
      int         value_mode;
      int         band_base;
      cfg_type    next_count;
      sample_type value;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // image count 1 out of reset, then 0 which acts as 1
      send_sample(8'd0);
      send_sample(8'd255);
      write_image_count(cfg_type'(0));
      send_sample(8'hAA);
      send_sample(8'h55);
      // odd count, even count with carry, even count rounding down
      write_image_count(cfg_type'(3));
      send_sample(8'd255);
      send_sample(8'd0);
      send_sample(8'd128);
      write_image_count(cfg_type'(4));
      send_sample(8'd255);
      send_sample(8'd0);
      send_sample(8'd255);
      send_sample(8'd255);
      send_sample(8'd9);
      send_sample(8'd3);
      send_sample(8'd0);
      send_sample(8'd4);
      // count lowered with two samples held
      send_sample(8'd200);
      send_sample(8'd100);
      write_image_count(cfg_type'(1));
      send_sample(8'd50);
      // count raised with one sample held
      write_image_count(cfg_type'(2));
      send_sample(8'd7);
      write_image_count(cfg_type'(5));
      send_sample(8'd1);
      send_sample(8'd2);
      send_sample(8'd3);
      send_sample(8'd4);

      phase = 0;
      while (samples_sent < SAMPLE_TARGET) begin
         gap_mode = $urandom_range(0, 2);
         if (phase == 0) begin
            next_count = cfg_type'(31);
         end else if (phase == 1) begin
            next_count = cfg_type'(MAX_IMAGES);
         end else if ($urandom_range(0, 9) == 0) begin
            next_count = cfg_type'($urandom_range(0, 31));
         end else begin
            next_count = cfg_type'($urandom_range(1, MAX_IMAGES));
         end
         write_image_count(next_count);
         phase_len  = $urandom_range(1, 150);
         value_mode = $urandom_range(0, 3);
         band_base  = $urandom_range(0, 248);
         repeat (phase_len) begin
            case (value_mode)
               1: value = sample_type'(band_base + $urandom_range(0, 7));
               2: value = ($urandom_range(0, 1) == 0) ? sample_type'($urandom_range(0, 1))
                                                      : sample_type'($urandom_range(254, 255));
               default: value = sample_type'($urandom_range(0, 255));
            endcase
            send_sample(value);
         end
         phase++;
      end
      wait_drained();

      $display("run: %0d samples over %0d image-count writes, %0d medians compared",
               samples_sent, count_writes, medians_checked);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/psm_pkg.sv
hw/rtl/psm_cell.sv
hw/rtl/psm_median.sv
hw/rtl/pixel_stack_median.sv
sim/pixel_stack_median_checker.sv
sim/pixel_stack_median_test.sv
